/* sv/mmbp_pkg.sv */
// Shared types, constants and the helper function of the multi-mode branch predictor.
package mmbp_pkg;

    // Default table geometry.
    localparam int GSHARE_MAX_BITS_DEF      = 14;
    localparam int CHOOSER_INDEX_BITS_DEF   = 11;
    localparam int GLOBAL_INDEX_BITS_DEF    = 12;
    localparam int LOCAL_PC_BITS_DEF        = 11;
    localparam int LOCAL_HISTORY_BITS_DEF   = 10;
    localparam int CHOOSER_COUNTER_BITS_DEF = 3;

    // Stream and configuration port geometry.
    localparam int PC_BITS       = 32;
    localparam int IN_TDATA_BITS = 40;
    localparam int OUT_TDATA_BITS = 8;
    localparam int CFG_DATA_BITS = 4;

    // Configuration register indexes.
    localparam logic CFG_MODE        = 1'b0;
    localparam logic CFG_GSHARE_BITS = 1'b1;

    // Predictor modes.
    localparam logic [1:0] MODE_STATIC     = 2'd0;
    localparam logic [1:0] MODE_GSHARE     = 2'd1;
    localparam logic [1:0] MODE_TOURNAMENT = 2'd2;
    localparam logic [1:0] MODE_HASHED     = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] GSHARE_BITS_RESET = 4'd14;

    // Reset values of the 2-bit counters.
    localparam logic [1:0] CNT_WEAK_NOT_TAKEN = 2'd1;
    localparam logic [1:0] CNT_WEAK_TAKEN     = 2'd2;

    // Request kinds carried on tuser.
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_TRAIN   = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ1,
        S_READ2
    } t_state;

    // 2-bit saturating counter step.
    function automatic logic [1:0] sat2(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        if (taken) begin
            r = (c == 2'd3) ? 2'd3 : c + 2'd1;
        end else begin
            r = (c == 2'd0) ? 2'd0 : c - 2'd1;
        end
        return r;
    endfunction

endpackage

/* sv/mmbp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module mmbp_ram
    import mmbp_pkg::*;
#(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/multi_mode_branch_predictor.sv */
// Top level of the multi-mode branch predictor: control sequencer, history and tables.
// A predict word passes READ1, READ2 and the output register to m_axis; a new word is
// taken once the last has left READ2, which follows the two dependent table reads
// (local history, then the local counter it selects). Reset: synchronous, active low.
// After reset the block sweeps every table to its reset value, one entry per cycle, over
// 2^(widest table index) entries (16384 at the defaults); s_axis_tready stays low
// meanwhile, while configuration writes are still taken.
module multi_mode_branch_predictor
    import mmbp_pkg::*;
#(
    parameter int GSHARE_MAX_BITS      = GSHARE_MAX_BITS_DEF,
    parameter int CHOOSER_INDEX_BITS   = CHOOSER_INDEX_BITS_DEF,
    parameter int GLOBAL_INDEX_BITS    = GLOBAL_INDEX_BITS_DEF,
    parameter int LOCAL_PC_BITS        = LOCAL_PC_BITS_DEF,
    parameter int LOCAL_HISTORY_BITS   = LOCAL_HISTORY_BITS_DEF,
    parameter int CHOOSER_COUNTER_BITS = CHOOSER_COUNTER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // Request stream.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // [31:0] pc, [32] outcome, rest zero
    input  logic                      s_axis_tuser,  // [0] req_type
    // Prediction stream.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata   // [0] prediction, rest zero
);

    // The global history is as wide as the widest index that it feeds.
    localparam int HB_A = (GSHARE_MAX_BITS > CHOOSER_INDEX_BITS) ?
                          GSHARE_MAX_BITS : CHOOSER_INDEX_BITS;
    localparam int HIST_BITS = (HB_A > GLOBAL_INDEX_BITS) ? HB_A : GLOBAL_INDEX_BITS;
    // The clearing sweep covers the deepest table.
    localparam int CB_A = (HIST_BITS > LOCAL_PC_BITS) ? HIST_BITS : LOCAL_PC_BITS;
    localparam int CLR_BITS = (CB_A > LOCAL_HISTORY_BITS) ? CB_A : LOCAL_HISTORY_BITS;

    localparam logic [CHOOSER_COUNTER_BITS-1:0] CHOOSER_MAX = '1;
    localparam logic [CHOOSER_COUNTER_BITS-1:0] CHOOSER_RESET =
        (CHOOSER_COUNTER_BITS == 1) ? CHOOSER_MAX : CHOOSER_COUNTER_BITS'(2);

    // ------------------------------------------------------------------
    // Configuration registers. Users write them only while idle; the block does not check.
    // ------------------------------------------------------------------
    logic [1:0]               r_mode;
    logic [CFG_DATA_BITS-1:0] r_gsh_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_STATIC;
            r_gsh_bits <= GSHARE_BITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:        r_mode     <= i_cfg_wdata[1:0];
                CFG_GSHARE_BITS: r_gsh_bits <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and captured request.
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [CLR_BITS-1:0]   r_clr_cnt;
    logic [HIST_BITS-1:0]  r_hist;
    logic                  r_train;
    logic                  r_outcome;
    logic [PC_BITS-1:0]    r_pc;
    logic                  r_out_valid;
    logic                  r_out_pred;

    logic in_accept;
    logic finish;      // the request in READ2 completes this cycle
    logic do_train;    // table and history updates take effect this cycle

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // A training word has no result and always completes; a prediction waits
    // until the output register is free or is being drained.
    assign finish   = (r_state == S_READ2) &&
                      (r_train || !r_out_valid || m_axis_tready);
    assign do_train = (r_state == S_READ2) && r_train && (r_mode != MODE_STATIC);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr_cnt) n_state = S_IDLE;
            S_IDLE:  if (in_accept) n_state = S_READ1;
            S_READ1: n_state = S_READ2;
            S_READ2: if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_train   <= (s_axis_tuser == REQ_TRAIN);
            r_pc      <= s_axis_tdata[PC_BITS-1:0];
            r_outcome <= s_axis_tdata[PC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Index generation. In IDLE the indices come straight from the incoming
    // word so that the tables are read on the accepting edge; later they are
    // recomputed from the captured pc for the write-back. The history only
    // moves at the end of READ2, so both see the same value.
    // ------------------------------------------------------------------
    logic [PC_BITS-1:0]            idx_pc;
    logic [GSHARE_MAX_BITS-1:0]    gsh_mask;
    logic [GSHARE_MAX_BITS-1:0]    gsh_idx;
    logic [GLOBAL_INDEX_BITS-1:0]  glb_idx;
    logic [CHOOSER_INDEX_BITS-1:0] chs_idx;
    logic [LOCAL_PC_BITS-1:0]      lht_idx;

    assign idx_pc = (r_state == S_IDLE) ? s_axis_tdata[PC_BITS-1:0] : r_pc;

    // A width above the gshare table size saturates, a width of zero gives index zero.
    always_comb begin
        for (int k = 0; k < GSHARE_MAX_BITS; k++) begin
            gsh_mask[k] = (k < int'(r_gsh_bits));
        end
    end

    assign gsh_idx = (idx_pc[GSHARE_MAX_BITS-1:0] ^ r_hist[GSHARE_MAX_BITS-1:0]) & gsh_mask;
    assign glb_idx = r_hist[GLOBAL_INDEX_BITS-1:0] ^
                     ((r_mode == MODE_HASHED) ? idx_pc[GLOBAL_INDEX_BITS-1:0] : '0);
    assign chs_idx = r_hist[CHOOSER_INDEX_BITS-1:0];
    assign lht_idx = idx_pc[LOCAL_PC_BITS-1:0];

    // ------------------------------------------------------------------
    // Tables.
    // ------------------------------------------------------------------
    logic                            clearing;
    logic [1:0]                      gsh_rdata, glb_rdata, lcn_rdata;
    logic [CHOOSER_COUNTER_BITS-1:0] chs_rdata;
    logic [LOCAL_HISTORY_BITS-1:0]   lht_rdata;

    logic [1:0]                      gsh_new, glb_new, lcn_new;
    logic [CHOOSER_COUNTER_BITS-1:0] chs_new;
    logic [LOCAL_HISTORY_BITS-1:0]   lht_new;

    logic                            tourn_train;
    logic                            gsh_train;

    assign clearing    = (r_state == S_CLEAR);
    assign gsh_train   = do_train && (r_mode == MODE_GSHARE);
    assign tourn_train = do_train && r_mode[1];

    mmbp_ram #(.WIDTH(2), .DEPTH(1 << GSHARE_MAX_BITS)) u_gshare (
        .i_clk   (i_clk),
        .i_we    (clearing || gsh_train),
        .i_waddr (clearing ? r_clr_cnt[GSHARE_MAX_BITS-1:0] : gsh_idx),
        .i_wdata (clearing ? CNT_WEAK_NOT_TAKEN : gsh_new),
        .i_re    (in_accept),
        .i_raddr (gsh_idx),
        .o_rdata (gsh_rdata)
    );

    mmbp_ram #(.WIDTH(2), .DEPTH(1 << GLOBAL_INDEX_BITS)) u_global (
        .i_clk   (i_clk),
        .i_we    (clearing || tourn_train),
        .i_waddr (clearing ? r_clr_cnt[GLOBAL_INDEX_BITS-1:0] : glb_idx),
        .i_wdata (clearing ? CNT_WEAK_TAKEN : glb_new),
        .i_re    (in_accept),
        .i_raddr (glb_idx),
        .o_rdata (glb_rdata)
    );

    mmbp_ram #(.WIDTH(CHOOSER_COUNTER_BITS), .DEPTH(1 << CHOOSER_INDEX_BITS)) u_chooser (
        .i_clk   (i_clk),
        .i_we    (clearing || tourn_train),
        .i_waddr (clearing ? r_clr_cnt[CHOOSER_INDEX_BITS-1:0] : chs_idx),
        .i_wdata (clearing ? CHOOSER_RESET : chs_new),
        .i_re    (in_accept),
        .i_raddr (chs_idx),
        .o_rdata (chs_rdata)
    );

    mmbp_ram #(.WIDTH(LOCAL_HISTORY_BITS), .DEPTH(1 << LOCAL_PC_BITS)) u_local_hist (
        .i_clk   (i_clk),
        .i_we    (clearing || tourn_train),
        .i_waddr (clearing ? r_clr_cnt[LOCAL_PC_BITS-1:0] : lht_idx),
        .i_wdata (clearing ? '0 : lht_new),
        .i_re    (in_accept),
        .i_raddr (lht_idx),
        .o_rdata (lht_rdata)
    );

    // The local counter is addressed by the pattern read from the local
    // history table, so its read is issued afterwards, in READ1. The
    // pattern stays on the history RAM's output until the next accept.
    mmbp_ram #(.WIDTH(2), .DEPTH(1 << LOCAL_HISTORY_BITS)) u_local_cnt (
        .i_clk   (i_clk),
        .i_we    (clearing || tourn_train),
        .i_waddr (clearing ? r_clr_cnt[LOCAL_HISTORY_BITS-1:0] : lht_rdata),
        .i_wdata (clearing ? CNT_WEAK_TAKEN : lcn_new),
        .i_re    (r_state == S_READ1),
        .i_raddr (lht_rdata),
        .o_rdata (lcn_rdata)
    );

    // ------------------------------------------------------------------
    // Prediction and update, evaluated in READ2 with all read data stable.
    // ------------------------------------------------------------------
    logic glb_pred, lcl_pred, pred;

    assign glb_pred = glb_rdata[1];
    assign lcl_pred = lcn_rdata[1];

    always_comb begin
        case (r_mode)
            MODE_STATIC:     pred = 1'b1;
            MODE_GSHARE:     pred = gsh_rdata[1];
            MODE_TOURNAMENT,
            MODE_HASHED:     pred = chs_rdata[CHOOSER_COUNTER_BITS-1] ? glb_pred : lcl_pred;
            default:         pred = 1'b1;
        endcase
    end

    assign gsh_new = sat2(gsh_rdata, r_outcome);
    assign glb_new = sat2(glb_rdata, r_outcome);
    assign lcn_new = sat2(lcn_rdata, r_outcome);
    assign lht_new = {lht_rdata[LOCAL_HISTORY_BITS-2:0], r_outcome};

    // The chooser moves only when the two component predictions disagree:
    // towards global when the global side was right, towards local otherwise.
    always_comb begin
        chs_new = chs_rdata;
        if (glb_pred != lcl_pred) begin
            if (glb_pred == r_outcome) begin
                if (chs_rdata != CHOOSER_MAX) chs_new = chs_rdata + 1'b1;
            end else begin
                if (chs_rdata != '0) chs_new = chs_rdata - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (do_train) begin
            r_hist <= {r_hist[HIST_BITS-2:0], r_outcome};
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds one prediction word while a new request is
    // already being accepted and read.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish && !r_train) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish && !r_train) begin
            r_out_pred <= pred;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, r_out_pred};

endmodule
